// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the speed estimator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define SLES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SLES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLES_ASSERT(lbl, prop, msg)
`define SLES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sles_pkg.sv =====
// Package of the slew-limited speed estimator: constants, codes, command and
// status types and the saturation helper. No dependencies.
package sles_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned SlewW     = 31;
  localparam int unsigned LimitW    = 10;
  localparam int unsigned StaleW    = 11;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned NumW      = 42;  // |position difference| * 1000 < 2^42
  localparam int unsigned DivSteps  = NumW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [9:0]        SpeedScale     = 10'd1000;
  localparam logic [StaleW-1:0] StaleMax       = 11'd2047;
  localparam logic [SlewW-1:0]  SlewStepReset  = 31'd655360;
  localparam logic [LimitW-1:0] StaleLimitReset = 10'd200;

  localparam logic [CfgIdxW-1:0] CfgSlewStep   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgStaleLimit = 8'd1;

  localparam logic signed [33:0] S34Max = 34'sd2147483647;
  localparam logic signed [33:0] S34Min = -34'sd2147483648;

  typedef struct packed {
    logic capture;   // register the accepted input transaction
    logic load;      // compare timestamps, update state or start division
    logic div_step;  // one restoring division step
    logic slew;      // apply slew limit to the quotient
    logic publish;   // move the held speed into the output register
  } sles_cmd_t;

  typedef struct packed {
    logic same_time;
  } sles_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S34Max) begin
      r = 32'sh7fffffff;
    end else if (v < S34Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/slew_limited_speed_estimator_core.sv =====
// Top level of the slew-limited speed estimator: configuration registers,
// controller and datapath. Depends on sles_pkg, sles_ctrl, sles_dp.
//
// Usage: each input transaction carries a millisecond timestamp and a Q16.16
// position and yields exactly one filtered speed transaction. An item is
// taken when in_valid_i is high and in_stall_o is low; a result leaves when
// out_valid_o is high and out_stall_i is low.
// Sequence: a new timestamp passes through the load state, the bit-serial
// divider loop, the slew state and the output state before out_valid_o; a
// repeated timestamp goes from the load state straight to the output state.
// One item is worked on at a time, so no new item is taken until the last
// one has been handed to the output register.
// The output register holds the last result, so the next item is accepted
// while it waits; if the receiver stalls, the following result is held in
// the datapath while the controller waits in its output state until the register frees.
// Configuration: slew_step (index 0) and stale_limit (index 1) are written
// through the cfg channel, which is always ready; write only while idle.
// Reset clears the stored time, position, speed and stale count and loads
// the configuration defaults.
module slew_limited_speed_estimator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sles_pkg::DataW-1:0]          timestamp_ms_i,
  input  logic signed [sles_pkg::DataW-1:0]   position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sles_pkg::DataW-1:0]   filtered_speed_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sles_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [sles_pkg::DataW-1:0]          cfg_data_i
);

`include "assert_macros.svh"

  logic [sles_pkg::SlewW-1:0]  slew_step_q;
  logic [sles_pkg::LimitW-1:0] stale_limit_q;
  sles_pkg::sles_cmd_t         cmd;
  sles_pkg::sles_status_t      status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_step_q   <= sles_pkg::SlewStepReset;
      stale_limit_q <= sles_pkg::StaleLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sles_pkg::CfgSlewStep:   slew_step_q   <= cfg_data_i[sles_pkg::SlewW-1:0];
        sles_pkg::CfgStaleLimit: stale_limit_q <= cfg_data_i[sles_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  sles_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sles_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .slew_step_i      (slew_step_q),
    .stale_limit_i    (stale_limit_q),
    .timestamp_ms_i   (timestamp_ms_i),
    .position_i       (position_i),
    .filtered_speed_o (filtered_speed_o)
  );

  // An accepted transaction keeps the block busy in the following cycle.
  `SLES_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "input accepted but block not busy afterwards")
  // A result is only moved into the output register when it is free.
  `SLES_ASSERT(a_publish_free, !cmd.publish || !out_valid_o || !out_stall_i,
    "result published over a stalled output")
  // The divider only runs while the input side is closed.
  `SLES_ASSERT(a_div_busy, !cmd.div_step || in_stall_o,
    "division step while accepting input")

endmodule

// ===== rtl/sles_ctrl.sv =====
// Controller of the speed estimator: sequences capture, division, slew and
// output hand-off. Depends on sles_pkg.
module sles_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sles_pkg::sles_status_t status_i,
  output sles_pkg::sles_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSlew = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [sles_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = status_i.same_time ? StFin : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == sles_pkg::DivCntW'(sles_pkg::DivSteps - 1)) begin
          state_d = StSlew;
        end
      end
      StSlew: begin
        cmd_o.slew = 1'b1;
        state_d    = StFin;
      end
      StFin: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd_o.publish ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/sles_dp.sv =====
// Datapath of the speed estimator: sample registers, bit-serial divider,
// slew limiter, stale counter and output register. Depends on sles_pkg.
module sles_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sles_pkg::sles_cmd_t                cmd_i,
  output sles_pkg::sles_status_t             status_o,
  input  logic [sles_pkg::SlewW-1:0]         slew_step_i,
  input  logic [sles_pkg::LimitW-1:0]        stale_limit_i,
  input  logic [sles_pkg::DataW-1:0]         timestamp_ms_i,
  input  logic signed [sles_pkg::DataW-1:0]  position_i,
  output logic signed [sles_pkg::DataW-1:0]  filtered_speed_o
);

  localparam int unsigned NumW = sles_pkg::NumW;

  logic [31:0]        t_q;
  logic signed [31:0] pos_q;
  logic [31:0]        prev_time_q;
  logic signed [31:0] prev_pos_q;
  logic signed [31:0] held_q;
  logic [sles_pkg::StaleW-1:0] stale_q;
  logic [31:0]        rem_q;
  logic [NumW-1:0]    quo_q;
  logic [31:0]        den_q;
  logic               neg_q;
  logic signed [31:0] out_q;

  logic signed [32:0] dp;
  logic [32:0]        dp_mag;
  logic [NumW-1:0]    num_mag;
  logic [31:0]        dt;
  logic [sles_pkg::StaleW-1:0] stale_inc;
  logic               stale_over;

  logic [32:0]        rem_sh;
  logic               ge;
  logic [32:0]        rem_sub;

  logic [32:0]        q_clip;
  logic signed [33:0] q_signed;
  logic signed [31:0] raw;
  logic signed [33:0] raw34, held34, step34, diff;
  logic signed [31:0] held_slewed;

  assign status_o.same_time = (t_q == prev_time_q);

  // Operands of the speed division.
  assign dt      = t_q - prev_time_q;
  assign dp      = $signed({pos_q[31], pos_q}) - $signed({prev_pos_q[31], prev_pos_q});
  assign dp_mag  = dp[32] ? 33'(-dp) : 33'(dp);
  assign num_mag = NumW'(dp_mag) * NumW'(sles_pkg::SpeedScale);

  assign stale_inc  = (stale_q == sles_pkg::StaleMax) ? stale_q : stale_q + 1'b1;
  assign stale_over = (stale_inc > sles_pkg::StaleW'(stale_limit_i));

  // Restoring division, one quotient bit a cycle; the dividend shifts out of
  // quo_q as the quotient shifts in.
  assign rem_sh  = {rem_q, quo_q[NumW-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Anything at or above 2^32 saturates either way, so clip it there first.
  assign q_clip   = (|quo_q[NumW-1:33]) ? 33'h1_0000_0000 : quo_q[32:0];
  assign q_signed = neg_q ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
  assign raw      = sles_pkg::sat32(q_signed);

  assign raw34  = 34'(raw);
  assign held34 = 34'(held_q);
  assign step34 = $signed({3'b000, slew_step_i});
  assign diff   = raw34 - held34;

  always_comb begin
    if (diff < -step34) begin
      held_slewed = sles_pkg::sat32(held34 - step34);
    end else if (diff > step34) begin
      held_slewed = sles_pkg::sat32(held34 + step34);
    end else begin
      held_slewed = raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      prev_pos_q  <= '0;
      held_q      <= '0;
      stale_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        if (status_o.same_time) begin
          stale_q <= stale_inc;
          if (stale_over) begin
            held_q <= '0;
          end
        end else begin
          stale_q     <= '0;
          prev_time_q <= t_q;
          prev_pos_q  <= pos_q;
        end
      end
      if (cmd_i.slew) begin
        held_q <= held_slewed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q   <= timestamp_ms_i;
      pos_q <= position_i;
    end
    if (cmd_i.load) begin
      rem_q <= '0;
      quo_q <= num_mag;
      den_q <= dt;
      neg_q <= dp[32];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
    if (cmd_i.publish) begin
      out_q <= held_q;
    end
  end

  assign filtered_speed_o = out_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for slew_limited_speed_estimator_core.
// A behavioural speed predictor checks each filtered speed against directed and random
// sample streams under random idling and back-pressure. Depends on sles_pkg and the core.
`timescale 1ns / 100ps

module testbench;

  localparam longint SpeedMax = 64'sd2147483647;
  localparam longint SpeedMin = -64'sd2147483648;
  localparam int     SettleCycles = 60;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic [sles_pkg::DataW-1:0]         timestamp_ms_i;
  logic signed [sles_pkg::DataW-1:0]  position_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic signed [sles_pkg::DataW-1:0]  filtered_speed_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [sles_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [sles_pkg::DataW-1:0]         cfg_data_i;

  slew_limited_speed_estimator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .timestamp_ms_i   (timestamp_ms_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_speed_o (filtered_speed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Predictor state and its copy of the configuration.
  logic [31:0]        est_prev_time;
  logic signed [31:0] est_prev_pos;
  logic signed [31:0] est_speed;
  logic [10:0]        est_stale_count;
  logic [30:0]        est_slew_step;
  logic [9:0]         est_stale_limit;

  logic signed [31:0] expected_speeds[$];

  int unsigned failures;
  int unsigned samples_sent;
  int unsigned speeds_checked;
  int unsigned stale_zeroings;
  int unsigned saturated_rates;

  bit steady_flow;
  int hold_off_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic signed [31:0] clamp_speed(input longint v);
    if (v > SpeedMax) begin
      return 32'sh7fffffff;
    end
    if (v < SpeedMin) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void reset_estimator();
    est_prev_time   = '0;
    est_prev_pos    = '0;
    est_speed       = '0;
    est_stale_count = '0;
    est_slew_step   = sles_pkg::SlewStepReset;
    est_stale_limit = sles_pkg::StaleLimitReset;
  endfunction

  // Advances the predictor by one sample and returns the speed it should publish.
  function automatic logic signed [31:0] next_speed(input logic [31:0] ts,
                                                    input logic signed [31:0] pos);
    logic [31:0] dt_ms;
    longint      rate;
    longint      gap;
    longint      step;
    if (ts != est_prev_time) begin
      dt_ms = ts - est_prev_time;
      rate  = ((longint'(pos) - longint'(est_prev_pos)) * 1000) / longint'(dt_ms);
      if (rate > SpeedMax || rate < SpeedMin) begin
        saturated_rates++;
      end
      rate = longint'(clamp_speed(rate));
      gap  = rate - longint'(est_speed);
      step = longint'(est_slew_step);
      if (gap < -step) begin
        est_speed = clamp_speed(longint'(est_speed) - step);
      end else if (gap > step) begin
        est_speed = clamp_speed(longint'(est_speed) + step);
      end else begin
        est_speed = rate[31:0];
      end
      est_prev_time   = ts;
      est_prev_pos    = pos;
      est_stale_count = '0;
    end else if (est_stale_count != sles_pkg::StaleMax) begin
      est_stale_count++;
    end
    if (est_stale_count > {1'b0, est_stale_limit}) begin
      if (est_speed != 0) begin
        stale_zeroings++;
      end
      est_speed = '0;
    end
    return est_speed;
  endfunction

  // Offers one sample, optionally after a random gap, and holds it until it is taken.
  task automatic send_sample(input logic [31:0] ts, input logic signed [31:0] pos);
    int gap_cycles;
    gap_cycles = 0;
    if (!steady_flow && $urandom_range(0, 99) < 30) begin
      gap_cycles = $urandom_range(1, 50);
    end
    if (gap_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    timestamp_ms_i <= ts;
    position_i     <= pos;
    do @(posedge clk_i); while (in_stall_o);
    expected_speeds.push_back(next_speed(ts, pos));
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering samples and waits until every predicted speed has been seen.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_speeds.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes both registers; the block must be idle first.
  task automatic configure(input logic [30:0] slew, input logic [9:0] limit);
    logic [31:0] slew_word;
    logic [31:0] limit_word;
    slew_word  = {1'($urandom_range(0, 1)), slew};
    limit_word = {22'($urandom), limit};
    wait_for_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sles_pkg::CfgSlewStep;
    cfg_data_i  <= slew_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    est_slew_step = slew_word[30:0];
    @(negedge clk_i);
    cfg_index_i <= sles_pkg::CfgStaleLimit;
    cfg_data_i  <= limit_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    est_stale_limit = limit_word[9:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver stalls at random, or throughout a hold-off that a test requests.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= !steady_flow && ($urandom_range(0, 99) < 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_speeds.size() == 0) begin
        $error("filtered_speed: no result expected, got %0d", filtered_speed_o);
        failures++;
      end else begin
        if (filtered_speed_o !== expected_speeds[0]) begin
          $error("filtered_speed mismatch: expected %0d, actual %0d",
                 expected_speeds[0], filtered_speed_o);
          failures++;
        end
        void'(expected_speeds.pop_front());
        speeds_checked++;
      end
    end
  end

  // Default configuration straight after reset. The first sample repeats the
  // reset timestamp of zero, so it counts as stale rather than as a new sample.
  task automatic test_reset_state();
    send_sample(32'd0, 32'sh12345678);
    send_sample(32'd1, 32'sd65536);
    send_sample(32'd2, 32'sd131072);
    send_sample(32'hffffffff, 32'sh7fffffff);
    send_sample(32'd2, 32'sh80000000);
  endtask

  // Rate saturation both ways and the widest and narrowest slew steps.
  task automatic test_slew_extremes();
    configure(31'h7fffffff, 10'd200);
    send_sample(32'd3, 32'sh7fffffff);
    send_sample(32'd4, 32'sh80000000);
    send_sample(32'd5, 32'sh80000000);
    send_sample(32'd6, 32'sh7fffffff);
    configure(31'd0, 10'd200);
    send_sample(32'd7, 32'sd100000);
    send_sample(32'd9, -32'sd100000);
  endtask

  // Repeated timestamps force the speed to zero once the limit is passed.
  task automatic test_stale_timeout();
    configure(31'd5000000, 10'd0);
    send_sample(32'd20, 32'sd65536);
    send_sample(32'd20, 32'sd0);
    send_sample(32'd21, 32'sd131072);
    configure(31'd5000000, 10'd3);
    repeat (5) send_sample(32'd21, 32'sd131072);
    send_sample(32'd25, 32'sd262144);
    configure(31'd5000000, 10'd1023);
    repeat (3) send_sample(32'd25, -32'sd9999);
  endtask

  // Mostly plausible tracks with short steps and bursts of repeated timestamps,
  // mixed with unrelated samples, across a series of register settings.
  task automatic test_random_tracks();
    logic [31:0]        ts;
    logic signed [31:0] pos;
    int                 repeats_left;
    int                 delta;
    ts           = $urandom;
    pos          = $urandom;
    repeats_left = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(31'h7fffffff, 10'd1023);
        1: configure(31'd0, 10'd0);
        2: configure(sles_pkg::SlewStepReset, sles_pkg::StaleLimitReset);
        default: begin
          configure($urandom_range(0, 1) ? 31'($urandom_range(0, 4000000)) : 31'($urandom),
                    ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 12)));
        end
      endcase
      steady_flow = (phase == 3);
      for (int n = 0; n < 100; n++) begin
        if (repeats_left > 0) begin
          repeats_left--;
          pos = $urandom;
        end else if ($urandom_range(0, 99) < 12) begin
          ts  = $urandom;
          pos = $urandom;
        end else begin
          if ($urandom_range(0, 99) < 8) begin
            repeats_left = $urandom_range(1, 15);
          end
          if ($urandom_range(0, 19) == 0) begin
            ts = ts + $urandom;
          end else begin
            ts = ts + $urandom_range(1, 20);
          end
          if ($urandom_range(0, 9) == 0) begin
            delta = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
          end else begin
            delta = int'($urandom_range(0, 2097152)) - 1048576;
          end
          pos = pos + delta;
        end
        send_sample(ts, pos);
      end
      steady_flow = 1'b0;
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so the
  // block fills up and stalls its input; then the sender waits for every result.
  task automatic test_backpressure();
    logic [31:0] ts;
    configure(31'd2000000, 10'd4);
    steady_flow   = 1'b1;
    hold_off_left = 400;
    ts = est_prev_time;
    for (int n = 0; n < 12; n++) begin
      ts = ts + ((n % 3 == 2) ? 32'd0 : 32'd1);
      send_sample(ts, $urandom);
    end
    steady_flow = 1'b0;
    wait_for_idle();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    timestamp_ms_i = '0;
    position_i     = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = sles_pkg::CfgSlewStep;
    cfg_data_i     = '0;
    failures        = 0;
    samples_sent    = 0;
    speeds_checked  = 0;
    stale_zeroings  = 0;
    saturated_rates = 0;
    steady_flow     = 1'b0;
    hold_off_left   = 0;
    reset_estimator();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_slew_extremes();
    test_stale_timeout();
    test_backpressure();
    test_random_tracks();

    wait_for_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_speeds.size() != 0) begin
      $error("filtered_speed: %0d results never arrived", expected_speeds.size());
      failures++;
    end
    $display("Sent %0d samples and checked %0d speeds under random stalls and a long hold-off.",
             samples_sent, speeds_checked);
    $display("Seen %0d stale zeroings and %0d saturated rate estimates.",
             stale_zeroings, saturated_rates);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
